### hdl/kpc_pkg.sv
// Package for the key press classifier: press class codes, edge history codes,
// configuration register indexes, reset values and the configuration struct.
// Depends on nothing; every other file of the block refers to it by scoped names.
package kpc_pkg;

   // Field widths fixed by the result and request formats
   localparam int LEVEL_BITS  = 18;
   localparam int KEYS_OUT    = 18;
   localparam int CLASS_W     = 3;
   localparam int HIST_W      = 2;
   localparam int CNT_W       = 13;
   localparam int CFG_W       = 12;
   localparam int CSR_INDEX_W = 2;

   localparam int CLASSES_W   = KEYS_OUT * CLASS_W;
   localparam int HISTORIES_W = KEYS_OUT * HIST_W;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_DOUBLE_WINDOW = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_TIME     = 2'd1;

   // Register values after reset
   localparam logic [CFG_W-1:0] DOUBLE_WINDOW_RESET = 12'd300;
   localparam logic [CFG_W-1:0] LONG_TIME_RESET     = 12'd1000;

   // Edge history codes: previous level in the upper bit, current in the lower
   localparam logic [HIST_W-1:0] HIST_RISE = 2'b01;
   localparam logic [HIST_W-1:0] HIST_FALL = 2'b10;

   typedef enum logic [CLASS_W-1:0] {
      CLS_RAISED      = 3'd0,
      CLS_SINGLE      = 3'd1,
      CLS_SINGLE_LONG = 3'd2,
      CLS_DOUBLE      = 3'd3,
      CLS_DOUBLE_LONG = 3'd4
   } class_type;

   typedef struct packed {
      logic [CFG_W-1:0] double_press_window;
      logic [CFG_W-1:0] long_press_time;
   } cfg_type;

endpackage

### hdl/key_press_classifier.sv
// Top level of the key press classifier: request register, per-key cells
// whose state registers form the result, and the configuration registers.
// Depends on kpc_pkg, kpc_csr and kpc_key.
//
// Usage:
//   Each request transfer on req_ carries one tick: bit i of req_pressed_levels
//   is 1 while key i is pressed. Each tick yields exactly one result transfer
//   on rsp_ carrying a 3-bit class and a 2-bit edge history for each key.
//   A transfer happens on a rising edge with valid high and stall low.
//   The tick is held in a request register; when it advances, every key
//   updates in parallel (a decrement and a compare per countdown) straight
//   into its state registers, which drive the result payload.
//   rsp_valid rises as the result is loaded into the key state registers,
//   after the request register; the result transfers while rsp_stall is low.
//   Throughput: one tick per cycle unless a result is stalled; the request
//   register takes one more tick while a result waits. A stalled result and
//   the key state hold, and req_stall rises once the request register is full.
//   Configuration writes on csr_ are always ready and take effect at once;
//   write them only while the block is idle. Unknown indexes are dropped.
//   Reset (synchronous): no request or result held, all keys raised with
//   clear history, registers back to 300 and 1000 ticks.
module key_press_classifier #(
   parameter int NUM_KEYS = 18
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [kpc_pkg::LEVEL_BITS-1:0]      req_pressed_levels,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [kpc_pkg::CLASSES_W-1:0]       rsp_press_classes,
   output logic [kpc_pkg::HISTORIES_W-1:0]     rsp_edge_histories,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kpc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [kpc_pkg::CFG_W-1:0]           csr_data
);

   kpc_pkg::cfg_type                   cfg;
   logic                               req_valid_ff;
   logic                               req_valid_in;
   logic [kpc_pkg::LEVEL_BITS-1:0]     levels_ff;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic                               accept;
   logic                               advance;
   kpc_pkg::class_type                 key_class [NUM_KEYS];
   logic [kpc_pkg::HIST_W-1:0]         key_hist  [NUM_KEYS];

   kpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Move the held tick into the result stage unless the result is stalled
   assign advance   = req_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign req_valid_in = accept || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the levels of an accepted tick
   always_ff @(posedge clock) begin
      if (accept) begin
         levels_ff <= req_pressed_levels;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // One cell per key; keys beyond the request width see a released level
   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
      logic level;
      if (k < kpc_pkg::LEVEL_BITS) begin : g_lvl
         assign level = levels_ff[k];
      end else begin : g_nolvl
         assign level = 1'b0;
      end

      kpc_key u_key (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .level        (level),
         .cfg          (cfg),
         .press_class  (key_class[k]),
         .edge_history (key_hist[k])
      );
   end

   // Pack the result; slots without a key read as zero, extra keys are dropped
   for (genvar j = 0; j < kpc_pkg::KEYS_OUT; j++) begin : g_pack
      if (j < NUM_KEYS) begin : g_used
         assign rsp_press_classes[j*kpc_pkg::CLASS_W +: kpc_pkg::CLASS_W] = key_class[j];
         assign rsp_edge_histories[j*kpc_pkg::HIST_W +: kpc_pkg::HIST_W]  = key_hist[j];
      end else begin : g_empty
         assign rsp_press_classes[j*kpc_pkg::CLASS_W +: kpc_pkg::CLASS_W] = '0;
         assign rsp_edge_histories[j*kpc_pkg::HIST_W +: kpc_pkg::HIST_W]  = '0;
      end
   end

endmodule

### hdl/kpc_csr.sv
// Configuration registers of the key press classifier.
// Depends on kpc_pkg for register indexes, reset values and cfg_type.
module kpc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [kpc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [kpc_pkg::CFG_W-1:0]        csr_data,
   output kpc_pkg::cfg_type                 cfg
);

   kpc_pkg::cfg_type cfg_ff;
   kpc_pkg::cfg_type cfg_in;

   // Always able to take a write
   assign csr_ready = 1'b1;

   // Decode the register index; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            kpc_pkg::REG_DOUBLE_WINDOW: cfg_in.double_press_window = csr_data;
            kpc_pkg::REG_LONG_TIME:     cfg_in.long_press_time     = csr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.double_press_window <= kpc_pkg::DOUBLE_WINDOW_RESET;
         cfg_ff.long_press_time     <= kpc_pkg::LONG_TIME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/kpc_key.sv
// State and next-state logic of one key: edge history, press class and the
// double and long countdowns. Depends on kpc_pkg for codes, widths and cfg_type.
module kpc_key (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          level,
   input  kpc_pkg::cfg_type              cfg,
   output kpc_pkg::class_type            press_class,
   output logic [kpc_pkg::HIST_W-1:0]    edge_history
);

   localparam int CNT_W = kpc_pkg::CNT_W;

   logic [kpc_pkg::HIST_W-1:0] hist_ff;
   logic [kpc_pkg::HIST_W-1:0] hist_in;
   kpc_pkg::class_type         class_ff;
   kpc_pkg::class_type         class_in;
   logic signed [CNT_W-1:0]    dc_ff;
   logic signed [CNT_W-1:0]    dc_in;
   logic signed [CNT_W-1:0]    lc_ff;
   logic signed [CNT_W-1:0]    lc_in;

   logic signed [CNT_W-1:0]    win_cnt;
   logic signed [CNT_W-1:0]    long_cnt;
   logic signed [CNT_W:0]      win_m1;

   assign win_cnt  = $signed({1'b0, cfg.double_press_window});
   assign long_cnt = $signed({1'b0, cfg.long_press_time});
   assign win_m1   = $signed({2'b00, cfg.double_press_window}) - 14'sd1;

   // Work out the next state of the key for this tick
   always_comb begin
      hist_in  = {hist_ff[0], level};
      class_in = class_ff;
      dc_in    = dc_ff;
      lc_in    = lc_ff;

      // Start a press on a rising edge
      if (class_in == kpc_pkg::CLS_RAISED && hist_in == kpc_pkg::HIST_RISE) begin
         class_in = kpc_pkg::CLS_SINGLE;
      end

      // Run the double window; a second rising edge inside it gives double
      if (class_in == kpc_pkg::CLS_SINGLE || class_in == kpc_pkg::CLS_DOUBLE) begin
         dc_in = dc_ff - 13'sd1;
         if (dc_in <= 13'sd0) begin
            if (!level) begin
               class_in = kpc_pkg::CLS_RAISED;
            end else begin
               dc_in = -13'sd1;
            end
         end else if (hist_in == kpc_pkg::HIST_RISE
                      && $signed({dc_in[CNT_W-1], dc_in}) < win_m1
                      && class_in == kpc_pkg::CLS_SINGLE) begin
            class_in = kpc_pkg::CLS_DOUBLE;
            lc_in    = long_cnt;
         end
      end

      // Run the long countdown while pressed, reload both when raised
      if (class_in != kpc_pkg::CLS_RAISED) begin
         lc_in = lc_in - 13'sd1;
      end else begin
         dc_in = win_cnt;
         lc_in = long_cnt;
      end

      // Promote to the long form; a falling edge ends a long press
      if (lc_in <= 13'sd0) begin
         if (class_in == kpc_pkg::CLS_SINGLE) begin
            class_in = kpc_pkg::CLS_SINGLE_LONG;
         end else if (class_in == kpc_pkg::CLS_DOUBLE) begin
            class_in = kpc_pkg::CLS_DOUBLE_LONG;
         end else if (class_in == kpc_pkg::CLS_SINGLE_LONG
                      || class_in == kpc_pkg::CLS_DOUBLE_LONG) begin
            lc_in = -13'sd1;
            if (!level && hist_in == kpc_pkg::HIST_FALL) begin
               class_in = kpc_pkg::CLS_RAISED;
            end
         end
      end
   end

   // Hold the state unless a tick moves into the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff  <= '0;
         class_ff <= kpc_pkg::CLS_RAISED;
         dc_ff    <= $signed({1'b0, kpc_pkg::DOUBLE_WINDOW_RESET});
         lc_ff    <= $signed({1'b0, kpc_pkg::LONG_TIME_RESET});
      end else if (advance) begin
         hist_ff  <= hist_in;
         class_ff <= class_in;
         dc_ff    <= dc_in;
         lc_ff    <= lc_in;
      end
   end

   assign press_class  = class_ff;
   assign edge_history = hist_ff;

endmodule

### hdl/kpc_checker.sv
// Port-level checks for the key press classifier, bound to the top level.
// Depends on kpc_pkg for field widths and class codes.
module kpc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [kpc_pkg::CLASSES_W-1:0]       rsp_press_classes,
   input logic [kpc_pkg::HISTORIES_W-1:0]     rsp_edge_histories
);

   // True when every class field holds a defined code
   function automatic logic classes_legal(input logic [kpc_pkg::CLASSES_W-1:0] cls);
      logic ok;
      ok = 1'b1;
      for (int k = 0; k < kpc_pkg::KEYS_OUT; k++) begin
         if (cls[k*kpc_pkg::CLASS_W +: kpc_pkg::CLASS_W] > kpc_pkg::CLS_DOUBLE_LONG) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   // True when no key with a rising edge is reported as raised
   function automatic logic rise_not_raised(input logic [kpc_pkg::CLASSES_W-1:0] cls,
                                            input logic [kpc_pkg::HISTORIES_W-1:0] hist);
      logic ok;
      ok = 1'b1;
      for (int k = 0; k < kpc_pkg::KEYS_OUT; k++) begin
         if (hist[k*kpc_pkg::HIST_W +: kpc_pkg::HIST_W] == kpc_pkg::HIST_RISE
             && cls[k*kpc_pkg::CLASS_W +: kpc_pkg::CLASS_W] == kpc_pkg::CLS_RAISED) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_press_classes)
                                 && $stable(rsp_edge_histories))
      else $error("stalled result changed or dropped");

   // A fresh result follows an earlier request transfer
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching request transfer");

   // Nothing is offered straight after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered after reset");

   // Every reported class is a defined code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> classes_legal(rsp_press_classes))
      else $error("undefined press class reported");

   // A rising edge always leaves the key in a pressed class
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rise_not_raised(rsp_press_classes, rsp_edge_histories))
      else $error("key raised on a rising edge");

endmodule

bind key_press_classifier kpc_checker u_kpc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_press_classes  (rsp_press_classes),
   .rsp_edge_histories (rsp_edge_histories)
);

### verif/key_press_classifier_test.sv
`timescale 1ns / 1ps
// Self-checking bench for key_press_classifier: drives level ticks and register
// writes, predicts every class and edge history result and compares it on transfer.
// Depends on kpc_pkg and the key_press_classifier RTL.

module key_press_classifier_test;

   localparam int KEYS         = 18;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 150;
   localparam int PHASES       = 16;
   localparam int PHASE_TICKS  = 105;
   localparam int OPENING_LEN  = 24;

   // Indexes with no register behind them; writes there must be dropped
   localparam logic [kpc_pkg::CSR_INDEX_W-1:0] REG_SPARE_LOW  = 2'd2;
   localparam logic [kpc_pkg::CSR_INDEX_W-1:0] REG_SPARE_HIGH = 2'd3;

   localparam logic [kpc_pkg::LEVEL_BITS-1:0] ALL_KEYS  = '1;
   localparam logic [kpc_pkg::LEVEL_BITS-1:0] EVEN_KEYS = 18'h15555;
   localparam logic [kpc_pkg::LEVEL_BITS-1:0] ODD_KEYS  = 18'h2AAAA;

   // Tracks every key's edge history, class and countdowns, and keeps the
   // results still owed by the block
   class key_press_tracker;
      logic [kpc_pkg::CFG_W-1:0]       window;
      logic [kpc_pkg::CFG_W-1:0]       long_time;
      logic [kpc_pkg::HIST_W-1:0]      hist [KEYS];
      kpc_pkg::class_type              cls [KEYS];
      int                              double_left [KEYS];
      int                              long_left [KEYS];
      logic [kpc_pkg::CLASSES_W-1:0]   due_classes [$];
      logic [kpc_pkg::HISTORIES_W-1:0] due_histories [$];
      int                              mismatches;

      function new();
         window     = kpc_pkg::DOUBLE_WINDOW_RESET;
         long_time  = kpc_pkg::LONG_TIME_RESET;
         mismatches = 0;
         for (int k = 0; k < KEYS; k++) begin
            hist[k]        = '0;
            cls[k]         = kpc_pkg::CLS_RAISED;
            double_left[k] = int'(window);
            long_left[k]   = int'(long_time);
         end
      endfunction

      function void write_register(logic [kpc_pkg::CSR_INDEX_W-1:0] index,
                                   logic [kpc_pkg::CFG_W-1:0] data);
         case (index)
            kpc_pkg::REG_DOUBLE_WINDOW: window = data;
            kpc_pkg::REG_LONG_TIME:     long_time = data;
            default: ;
         endcase
      endfunction

      // Advance every key by one tick and queue the packed result
      function void take_tick(logic [kpc_pkg::LEVEL_BITS-1:0] levels);
         logic [kpc_pkg::CLASSES_W-1:0]   classes;
         logic [kpc_pkg::HISTORIES_W-1:0] hists;
         logic [kpc_pkg::HIST_W-1:0]      h;
         kpc_pkg::class_type              c;
         int                              dc;
         int                              lc;
         logic                            lv;
         classes = '0;
         hists   = '0;
         for (int k = 0; k < KEYS; k++) begin
            lv = levels[k];
            h  = {hist[k][0], lv};
            c  = cls[k];
            dc = double_left[k];
            lc = long_left[k];
            if (c == kpc_pkg::CLS_RAISED && h == kpc_pkg::HIST_RISE)
               c = kpc_pkg::CLS_SINGLE;
            // double window: expire, pin while held, or catch a second press
            if (c == kpc_pkg::CLS_SINGLE || c == kpc_pkg::CLS_DOUBLE) begin
               dc = dc - 1;
               if (dc <= 0) begin
                  if (!lv)
                     c = kpc_pkg::CLS_RAISED;
                  else
                     dc = -1;
               end else if (h == kpc_pkg::HIST_RISE && dc < int'(window) - 1
                            && c == kpc_pkg::CLS_SINGLE) begin
                  c  = kpc_pkg::CLS_DOUBLE;
                  lc = int'(long_time);
               end
            end
            if (c != kpc_pkg::CLS_RAISED) begin
               lc = lc - 1;
            end else begin
               dc = int'(window);
               lc = int'(long_time);
            end
            // long press promotion, and release out of a long class
            if (lc <= 0) begin
               if (c == kpc_pkg::CLS_SINGLE) begin
                  c = kpc_pkg::CLS_SINGLE_LONG;
               end else if (c == kpc_pkg::CLS_DOUBLE) begin
                  c = kpc_pkg::CLS_DOUBLE_LONG;
               end else if (c == kpc_pkg::CLS_SINGLE_LONG
                            || c == kpc_pkg::CLS_DOUBLE_LONG) begin
                  lc = -1;
                  if (!lv && h == kpc_pkg::HIST_FALL)
                     c = kpc_pkg::CLS_RAISED;
               end
            end
            hist[k]        = h;
            cls[k]         = c;
            double_left[k] = dc;
            long_left[k]   = lc;
            classes[kpc_pkg::CLASS_W*k +: kpc_pkg::CLASS_W] = c;
            hists[kpc_pkg::HIST_W*k +: kpc_pkg::HIST_W]     = h;
         end
         due_classes.push_back(classes);
         due_histories.push_back(hists);
      endfunction

      function int pending();
         return due_classes.size();
      endfunction

      task flag_mismatch(string what);
         $display("%0t mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      task compare_result(logic [kpc_pkg::CLASSES_W-1:0] classes,
                          logic [kpc_pkg::HISTORIES_W-1:0] hists);
         logic [kpc_pkg::CLASSES_W-1:0]   want_classes;
         logic [kpc_pkg::HISTORIES_W-1:0] want_hists;
         if (due_classes.size() == 0) begin
            flag_mismatch($sformatf("unexpected result, classes %h histories %h",
                                    classes, hists));
            return;
         end
         want_classes = due_classes.pop_front();
         want_hists   = due_histories.pop_front();
         if (classes !== want_classes)
            flag_mismatch($sformatf("press_classes %h, expected %h", classes, want_classes));
         if (hists !== want_hists)
            flag_mismatch($sformatf("edge_histories %h, expected %h", hists, want_hists));
      endtask
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [kpc_pkg::LEVEL_BITS-1:0]    req_pressed_levels;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [kpc_pkg::CLASSES_W-1:0]     rsp_press_classes;
   logic [kpc_pkg::HISTORIES_W-1:0]   rsp_edge_histories;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [kpc_pkg::CSR_INDEX_W-1:0]   csr_index;
   logic [kpc_pkg::CFG_W-1:0]         csr_data;

   key_press_tracker                  tracker;
   logic [kpc_pkg::LEVEL_BITS-1:0]    held_levels;
   bit                                quiet;
   bit                                hold_request;
   int                                cycle_count;

   logic [kpc_pkg::LEVEL_BITS-1:0] opening_ticks [OPENING_LEN] = '{
      18'h0, ALL_KEYS, 18'h0, ALL_KEYS, ALL_KEYS, ALL_KEYS, ALL_KEYS, 18'h0,
      18'h0, EVEN_KEYS, EVEN_KEYS, EVEN_KEYS, EVEN_KEYS, 18'h0, ODD_KEYS, 18'h0,
      18'h0, 18'h0, 18'h0, 18'h0, ALL_KEYS, ODD_KEYS, EVEN_KEYS, 18'h0
   };
   logic [kpc_pkg::CFG_W-1:0] fixed_window [8] = '{12'd2, 12'd4095, 12'd0, 12'd1,
                                                   12'd3, 12'd4095, 12'd2, 12'd5};
   logic [kpc_pkg::CFG_W-1:0] fixed_long [8]   = '{12'd1, 12'd4095, 12'd0, 12'd0,
                                                   12'd1, 12'd1, 12'd4095, 12'd8};

   key_press_classifier dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pressed_levels (req_pressed_levels),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_press_classes  (rsp_press_classes),
      .rsp_edge_histories (rsp_edge_histories),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Abort a hung run
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Observe every transfer at the clock edge it happens on
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            tracker.write_register(csr_index, csr_data);
         if (req_valid && !req_stall)
            tracker.take_tick(req_pressed_levels);
         if (rsp_valid && !rsp_stall)
            tracker.compare_result(rsp_press_classes, rsp_edge_histories);
      end
   end

   // Result side: random stall bursts, one long hold-off on request
   initial begin
      rsp_stall <= 1'b0;
      repeat (8) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_stall <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
      end
   end

   // Offer one tick and hold it until it transfers
   task automatic send_tick(input logic [kpc_pkg::LEVEL_BITS-1:0] levels);
      req_valid          <= 1'b1;
      req_pressed_levels <= levels;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic sender_gap();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clock);
   endtask

   task automatic write_reg(input logic [kpc_pkg::CSR_INDEX_W-1:0] index,
                            input logic [kpc_pkg::CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Wait until every owed result has come back, then let the pipeline settle
   task automatic drain();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      @(posedge clock);
      while (tracker.pending() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   // Mostly held keys that toggle now and then, with some pure noise ticks
   task automatic run_ticks(input int count, input int flip_span);
      logic [kpc_pkg::LEVEL_BITS-1:0] levels;
      for (int i = 0; i < count; i++) begin
         if (!quiet && $urandom_range(0, 5) == 0)
            sender_gap();
         if ($urandom_range(0, 9) == 0) begin
            levels = kpc_pkg::LEVEL_BITS'($urandom);
         end else begin
            for (int k = 0; k < KEYS; k++)
               if ($urandom_range(1, flip_span) == 1)
                  held_levels[k] = ~held_levels[k];
            levels = held_levels;
         end
         send_tick(levels);
      end
   endtask

   initial begin
      logic [kpc_pkg::CFG_W-1:0] window;
      logic [kpc_pkg::CFG_W-1:0] long_time;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_pressed_levels <= '0;
      csr_valid          <= 1'b0;
      csr_index          <= kpc_pkg::REG_DOUBLE_WINDOW;
      csr_data           <= '0;
      held_levels        = '0;
      quiet              = 1'b0;
      hold_request       = 1'b0;
      tracker            = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset register values first
      run_ticks(40, 8);
      drain();

      // short windows so the opening ticks reach double and long classes
      write_reg(kpc_pkg::REG_DOUBLE_WINDOW, 12'd4);
      write_reg(kpc_pkg::REG_LONG_TIME, 12'd3);
      csr_valid <= 1'b0;
      for (int i = 0; i < OPENING_LEN; i++)
         send_tick(opening_ticks[i]);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         if (p < 8) begin
            window    = fixed_window[p];
            long_time = fixed_long[p];
         end else begin
            window    = kpc_pkg::CFG_W'($urandom_range(2, 24));
            long_time = kpc_pkg::CFG_W'($urandom_range(1, 40));
         end
         write_reg(kpc_pkg::REG_DOUBLE_WINDOW, window);
         write_reg(kpc_pkg::REG_LONG_TIME, long_time);
         // writes to unused indexes must leave both registers alone
         if (p == 5 || p == 10) begin
            write_reg(REG_SPARE_LOW, kpc_pkg::CFG_W'($urandom));
            write_reg(REG_SPARE_HIGH, '1);
         end
         csr_valid <= 1'b0;
         if (p == 4)
            hold_request = 1'b1;
         if (p >= PHASES - 2)
            quiet = 1'b1;
         run_ticks(PHASE_TICKS, $urandom_range(2, 24));
         drain();
      end

      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
